// ===== rtl/vt4_pkg.sv =====
package vt4_pkg;

    localparam int COORD_W = 24;
    localparam int COEF_W  = 32;
    localparam int COLOR_W = 24;
    localparam int OUT_W   = 32;
    localparam int IDX_W   = 4;
    localparam int N_DIM   = 4;
    localparam int N_COEF  = N_DIM * N_DIM;
    localparam int PROD_W  = COORD_W + COEF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_op;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [OUT_W-1:0]   t_out;
    typedef logic        [COLOR_W-1:0] t_color;

    typedef struct packed {
        logic                is_xform;
        logic [IDX_W-1:0]    index;
        t_coef               value;
        t_coord [N_DIM-1:0]  vert;
        t_color              color;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q2b;

endpackage

// ===== rtl/vt4_in_if.sv =====
interface vt4_in_if
    import vt4_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [IDX_W-1:0] coef_index;
    t_coef            coef_value;
    t_coord           vert_x;
    t_coord           vert_y;
    t_coord           vert_z;
    t_coord           vert_w;
    t_color           vert_color;

    modport source (
        output valid, opcode, coef_index, coef_value,
        output vert_x, vert_y, vert_z, vert_w, vert_color,
        input  ready
    );

    modport sink (
        input  valid, opcode, coef_index, coef_value,
        input  vert_x, vert_y, vert_z, vert_w, vert_color,
        output ready
    );
endinterface

// ===== rtl/vt4_out_if.sv =====
interface vt4_out_if
    import vt4_pkg::*;
();
    logic   valid;
    logic   ready;
    t_out   out_x;
    t_out   out_y;
    t_out   out_z;
    t_out   out_w;
    t_color out_color;

    modport source (
        output valid, out_x, out_y, out_z, out_w, out_color,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_w, out_color,
        output ready
    );
endinterface

// ===== rtl/vt4_front.sv =====
module vt4_front
    import vt4_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    vt4_in_if.sink   i_vtx,
    input  logic     i_pop,
    output t_q2b     o_head
);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;
    logic               push;
    logic               pop;
    t_cmd               cmd;

    // classify the incoming transaction
    always_comb begin
        cmd.is_xform = (t_op'(i_vtx.opcode) == OP_XFORM);
        cmd.index    = i_vtx.coef_index;
        cmd.value    = i_vtx.coef_value;
        cmd.vert[0]  = i_vtx.vert_x;
        cmd.vert[1]  = i_vtx.vert_y;
        cmd.vert[2]  = i_vtx.vert_z;
        cmd.vert[3]  = i_vtx.vert_w;
        cmd.color    = i_vtx.vert_color;
    end

    assign i_vtx.ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push        = i_vtx.valid && i_vtx.ready;
    assign pop         = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

// ===== rtl/vt4_back.sv =====
module vt4_back
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q2b      i_head,
    output logic      o_pop,
    vt4_out_if.source o_res
);

    localparam int SH_W = SUM_W - FRAC_BITS;

    t_coef                                r_mat [N_COEF];
    logic signed [PROD_W-1:0]             r_prod [N_DIM][N_DIM];
    logic signed [SUM_W-1:0]              r_sum [N_DIM];
    t_out                                 r_out [N_DIM];
    t_color                               r_p_color;
    t_color                               r_s_color;
    t_color                               r_out_color;
    logic                                 r_p_valid;
    logic                                 r_s_valid;
    logic                                 r_out_valid;
    logic                                 en;
    logic                                 load;
    logic signed [SUM_W-1:0]              shifted [N_DIM];
    t_out                                 sat [N_DIM];

    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en && i_head.valid;
    assign load  = o_pop && !i_head.cmd.is_xform;

    // coefficient store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_COEF; i++) begin
                r_mat[i] <= (i % (N_DIM + 1) == 0) ? (COEF_W'(1) << FRAC_BITS) : '0;
            end
        end else if (load) begin
            r_mat[i_head.cmd.index] <= i_head.cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_p_valid   <= o_pop && i_head.cmd.is_xform;
            r_s_valid   <= r_p_valid;
            r_out_valid <= r_s_valid;
        end
    end

    // products, row sums, then shift and saturate
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < N_DIM; r++) begin
                for (int c = 0; c < N_DIM; c++) begin
                    r_prod[r][c] <= PROD_W'(i_head.cmd.vert[c]) * PROD_W'(r_mat[r*N_DIM+c]);
                end
                r_sum[r] <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                          + SUM_W'(r_prod[r][2]) + SUM_W'(r_prod[r][3]);
                r_out[r] <= sat[r];
            end
            r_p_color   <= i_head.cmd.color;
            r_s_color   <= r_p_color;
            r_out_color <= r_s_color;
        end
    end

    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            shifted[r] = r_sum[r] >>> FRAC_BITS;
            if ((&shifted[r][SH_W-1:OUT_W-1]) || !(|shifted[r][SH_W-1:OUT_W-1])) begin
                sat[r] = shifted[r][OUT_W-1:0];
            end else if (shifted[r][SH_W-1]) begin
                sat[r] = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                sat[r] = {1'b0, {(OUT_W-1){1'b1}}};
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_x     = r_out[0];
    assign o_res.out_y     = r_out[1];
    assign o_res.out_z     = r_out[2];
    assign o_res.out_w     = r_out[3];
    assign o_res.out_color = r_out_color;

endmodule

// ===== rtl/vertex_transform_4x4.sv =====
// 4x4 homogeneous vertex transformer. Each input transaction either loads one
// Q(32-FRAC_BITS).FRAC_BITS matrix coefficient (no result) or transforms a
// vertex into four row dot products, floored by 2^FRAC_BITS and saturated to
// signed 32 bits, colour passed through. The matrix is the identity after
// reset. One transaction is taken per cycle while the queue is not full; a
// four-entry queue sits between the input decode and the 16-multiplier
// datapath; a result passes the queue, product, sum and output registers.
// Loads and transforms take effect strictly in arrival order, so a load never
// alters a vertex already accepted. Rate is set by the fully pipelined multiply,
// sum and saturate stages: one vertex per cycle while the output is taken.
module vertex_transform_4x4
    import vt4_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vt4_in_if.sink    i_vtx,
    vt4_out_if.source o_vtx
);

    t_q2b head;
    logic pop;

    vt4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_pop   (pop),
        .o_head  (head)
    );

    vt4_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_vtx)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_full_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vtx.ready |-> head.valid)
        else $error("queue full but head not valid");

    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vtx.valid && !o_vtx.ready) |-> !pop)
        else $error("queue popped while output stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_vtx.valid)
        else $error("result valid straight after reset");

endmodule
